// File: design/key_gesture_servo_selector_defines.svh
// assertion macros for the key gesture servo selector
// used by the top level, expects clock and reset in scope
`ifndef KEY_GESTURE_SERVO_SELECTOR_DEFINES_SVH
`define KEY_GESTURE_SERVO_SELECTOR_DEFINES_SVH

// same-cycle implication
`define KGSS_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kgss assertion failed");

// next-cycle implication
`define KGSS_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kgss assertion failed");

`endif

// File: design/kgss_pkg.sv
// shared types, codes and register defaults for the key gesture servo selector
// no dependencies
package kgss_pkg;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DEB1    = 3'd1,
      PH_PRESSED = 3'd2,
      PH_WAIT    = 3'd3,
      PH_DEB2    = 3'd4,
      PH_HOLDOFF = 3'd5
   } phase_type;

   localparam logic [1:0] GEST_NONE   = 2'd0;
   localparam logic [1:0] GEST_CLICK  = 2'd1;
   localparam logic [1:0] GEST_LONG   = 2'd2;
   localparam logic [1:0] GEST_DOUBLE = 2'd3;

   localparam logic [1:0] SET_CLICK  = 2'd0;
   localparam logic [1:0] SET_LONG   = 2'd1;
   localparam logic [1:0] SET_DOUBLE = 2'd2;

   localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
   localparam logic [2:0] REG_LONG        = 3'd1;
   localparam logic [2:0] REG_DOUBLE      = 3'd2;
   localparam logic [2:0] REG_HOLDOFF     = 3'd3;
   localparam logic [2:0] REG_DUTY_CLICK  = 3'd4;
   localparam logic [2:0] REG_DUTY_LONG   = 3'd5;
   localparam logic [2:0] REG_DUTY_DOUBLE = 3'd6;

   localparam logic [7:0]  DEF_DEBOUNCE    = 8'd20;
   localparam logic [15:0] DEF_LONG        = 16'd1000;
   localparam logic [15:0] DEF_DOUBLE      = 16'd500;
   localparam logic [7:0]  DEF_HOLDOFF     = 8'd50;
   localparam logic [15:0] DEF_DUTY_CLICK  = 16'd50;
   localparam logic [15:0] DEF_DUTY_LONG   = 16'd150;
   localparam logic [15:0] DEF_DUTY_DOUBLE = 16'd250;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] long_ticks;
      logic [15:0] double_ticks;
      logic [7:0]  holdoff_ticks;
      logic [15:0] duty_click;
      logic [15:0] duty_long;
      logic [15:0] duty_double;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  gesture;
      logic [1:0]  servo_choice;
      logic [15:0] compare_value;
      logic        led_level;
   } result_type;

endpackage

// File: design/kgss_csr.sv
// configuration registers of the key gesture servo selector
// depends on kgss_pkg
module kgss_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output kgss_pkg::cfg_type cfg
);
   import kgss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_DEBOUNCE:    cfg_in.debounce_ticks = csr_data[7:0];
            REG_LONG:        cfg_in.long_ticks     = csr_data;
            REG_DOUBLE:      cfg_in.double_ticks   = csr_data;
            REG_HOLDOFF:     cfg_in.holdoff_ticks  = csr_data[7:0];
            REG_DUTY_CLICK:  cfg_in.duty_click     = csr_data;
            REG_DUTY_LONG:   cfg_in.duty_long      = csr_data;
            REG_DUTY_DOUBLE: cfg_in.duty_double    = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEF_DEBOUNCE;
         cfg_ff.long_ticks     <= DEF_LONG;
         cfg_ff.double_ticks   <= DEF_DOUBLE;
         cfg_ff.holdoff_ticks  <= DEF_HOLDOFF;
         cfg_ff.duty_click     <= DEF_DUTY_CLICK;
         cfg_ff.duty_long      <= DEF_DUTY_LONG;
         cfg_ff.duty_double    <= DEF_DUTY_DOUBLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/kgss_step.sv
// gesture state machine: phase, tick counters, setting and led
// depends on kgss_pkg
module kgss_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                key_down,
   input  kgss_pkg::cfg_type   cfg,
   output kgss_pkg::result_type result
);
   import kgss_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  short_count_ff, short_count_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [1:0]  setting_ff, setting_in;
   logic        led_ff, led_in;
   logic [1:0]  gesture;

   logic [7:0]  sc_inc;
   logic [15:0] el_inc;
   logic        deb_zero;
   logic        hold_zero;
   logic        deb_done;
   logic        hold_done;
   logic        el_below_long;
   logic        el_below_double;
   phase_type   after_double;

   assign sc_inc          = (short_count_ff == 8'hFF) ? short_count_ff : short_count_ff + 8'd1;
   assign el_inc          = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign deb_zero        = (cfg.debounce_ticks == 8'd0);
   assign hold_zero       = (cfg.holdoff_ticks == 8'd0);
   assign deb_done        = (sc_inc >= cfg.debounce_ticks);
   assign hold_done       = (sc_inc >= cfg.holdoff_ticks);
   assign el_below_long   = (el_inc < cfg.long_ticks);
   assign el_below_double = (el_inc < cfg.double_ticks);
   assign after_double    = hold_zero ? PH_IDLE : PH_HOLDOFF;

   // next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_DEB1: begin
            if (deb_done) phase_in = key_down ? PH_PRESSED : PH_IDLE;
         end
         PH_PRESSED: begin
            if (!key_down) phase_in = el_below_long ? PH_WAIT : PH_IDLE;
         end
         PH_WAIT: begin
            if (el_below_double) begin
               if (key_down) phase_in = deb_zero ? after_double : PH_DEB2;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_DEB2: begin
            if (deb_done) phase_in = key_down ? after_double : PH_WAIT;
         end
         PH_HOLDOFF: begin
            if (hold_done) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            if (key_down) phase_in = deb_zero ? PH_PRESSED : PH_DEB1;
         end
      endcase
   end

   // counters and event
   always_comb begin
      short_count_in = short_count_ff;
      elapsed_in     = elapsed_ff;
      gesture        = GEST_NONE;
      case (phase_ff)
         PH_DEB1: begin
            short_count_in = sc_inc;
            elapsed_in     = el_inc;
         end
         PH_PRESSED: begin
            elapsed_in = el_inc;
            if (!key_down) begin
               if (el_below_long) elapsed_in = 16'd0;
               else gesture = GEST_LONG;
            end
         end
         PH_WAIT: begin
            elapsed_in = el_inc;
            if (el_below_double) begin
               if (key_down) begin
                  short_count_in = 8'd0;
                  if (deb_zero) gesture = GEST_DOUBLE;
               end
            end else begin
               gesture = GEST_CLICK;
            end
         end
         PH_DEB2: begin
            short_count_in = sc_inc;
            elapsed_in     = el_inc;
            if (deb_done && key_down) begin
               gesture        = GEST_DOUBLE;
               short_count_in = 8'd0;
            end
         end
         PH_HOLDOFF: begin
            short_count_in = sc_inc;
         end
         default: begin
            if (key_down) begin
               elapsed_in     = 16'd0;
               short_count_in = 8'd0;
            end
         end
      endcase
   end

   always_comb begin
      setting_in = setting_ff;
      led_in     = led_ff;
      if (gesture != GEST_NONE) begin
         setting_in = gesture - 2'd1;
         led_in     = ~led_ff;
      end
      result.gesture      = gesture;
      result.servo_choice = setting_in;
      result.led_level    = led_in;
      case (setting_in)
         SET_LONG:   result.compare_value = cfg.duty_long;
         SET_DOUBLE: result.compare_value = cfg.duty_double;
         default:    result.compare_value = cfg.duty_click;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         short_count_ff <= 8'd0;
         elapsed_ff     <= 16'd0;
         setting_ff     <= SET_CLICK;
         led_ff         <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         short_count_ff <= short_count_in;
         elapsed_ff     <= elapsed_in;
         setting_ff     <= setting_in;
         led_ff         <= led_in;
      end
   end

endmodule

// File: design/key_gesture_servo_selector.sv
// key gesture servo selector: req beats pass through an input register, then an output register
// throughput one beat per cycle; a held rsp beat only stalls req once the input register is full
// reset clears phase, counters, setting, led and both valid flags and loads register defaults
// depends on kgss_pkg, kgss_csr, kgss_step and key_gesture_servo_selector_defines.svh
`include "key_gesture_servo_selector_defines.svh"
module key_gesture_servo_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_key_down,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_gesture,
   output logic [1:0]  rsp_servo_choice,
   output logic [15:0] rsp_compare_value,
   output logic        rsp_led_level,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import kgss_pkg::*;

   cfg_type    cfg;
   result_type step_res;
   result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic key_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load;
   logic in_load;
   logic step_en;

   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign step_en      = in_valid_ff && out_load;
   assign in_load      = !in_valid_ff || out_load;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_load ? in_valid_ff : rsp_valid_ff;

   kgss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   kgss_step u_step (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .key_down (key_ff),
      .cfg      (cfg),
      .result   (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // beat payloads
   always_ff @(posedge clock) begin
      if (in_load && req_valid) key_ff <= req_key_down;
      if (step_en) rsp_ff <= step_res;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gesture       = rsp_ff.gesture;
   assign rsp_servo_choice  = rsp_ff.servo_choice;
   assign rsp_compare_value = rsp_ff.compare_value;
   assign rsp_led_level     = rsp_ff.led_level;

   `KGSS_IMPLIES(a_stall_only_when_full, req_stall, in_valid_ff)
   `KGSS_IMPLIES(a_choice_legal, rsp_valid, rsp_servo_choice != 2'd3)
   `KGSS_IMPLIES(a_event_sets_choice, rsp_valid && rsp_gesture != GEST_NONE,
      rsp_servo_choice == rsp_gesture - 2'd1)
   `KGSS_NEXT(a_step_led_follows, step_en && step_res.gesture == GEST_NONE && !reset,
      rsp_led_level == $past(step_res.led_level))

endmodule

// File: sim/tb_key_gesture_servo_selector.sv
// testbench for key_gesture_servo_selector: drives key sample beats, predicts every rsp beat
// and checks it field by field, across several register settings including the extremes
// depends on kgss_pkg and the key_gesture_servo_selector top level
module tb_key_gesture_servo_selector;
   import kgss_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int RANDOM_TICKS = 560;
   localparam int RANDOM_SETTINGS = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_key_down = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_gesture;
   logic [1:0]  rsp_servo_choice;
   logic [15:0] rsp_compare_value;
   logic        rsp_led_level;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = REG_DEBOUNCE;
   logic [15:0] csr_data = '0;

   // predictor state and its copy of the registers
   cfg_type     model_cfg = '{DEF_DEBOUNCE, DEF_LONG, DEF_DOUBLE, DEF_HOLDOFF,
                              DEF_DUTY_CLICK, DEF_DUTY_LONG, DEF_DUTY_DOUBLE};
   phase_type   key_phase = PH_IDLE;
   logic [7:0]  tick_count = '0;
   logic [15:0] elapsed_ticks = '0;
   logic [1:0]  servo_setting = SET_CLICK;
   logic        led_state = 1'b0;

   bit          key_samples[$];
   result_type  predicted_results[$];

   int          send_gap = 0;
   int          stall_gap = 0;
   bit          quiet = 1'b0;
   bit          req_accepted = 1'b0;
   int          error_count = 0;
   int          cycle_count = 0;

   // settings that go through the directed press pattern
   cfg_type directed_cfgs[5] = '{
      '{8'd2, 16'd8, 16'd6, 8'd3, 16'hFFFF, 16'h0000, 16'h5A5A},
      '{8'd0, 16'd0, 16'd0, 8'd0, 16'h0000, 16'hFFFF, 16'hA5A5},
      '{8'd0, 16'd5, 16'd0, 8'd0, 16'h1234, 16'h8000, 16'h0001},
      '{8'd0, 16'd5, 16'd3, 8'd0, 16'h7FFF, 16'h0001, 16'hFFFF},
      '{8'd1, 16'd1, 16'd1, 8'd1, 16'h0001, 16'hFFFE, 16'h0000}
   };
   // press and release run lengths, starting with a press
   int pattern_runs[18] = '{2, 4, 4, 10, 12, 3, 4, 2, 5, 6, 4, 2, 1, 10, 4, 4, 4, 8};

   key_gesture_servo_selector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_down      (req_key_down),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gesture       (rsp_gesture),
      .rsp_servo_choice  (rsp_servo_choice),
      .rsp_compare_value (rsp_compare_value),
      .rsp_led_level     (rsp_led_level),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] bump8(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void queue_level(input bit level, input int n);
      repeat (n) key_samples.push_back(level);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 50)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic start_holdoff();
      tick_count = '0;
      key_phase = (model_cfg.holdoff_ticks == 0) ? PH_IDLE : PH_HOLDOFF;
   endtask

   // one key sample through the gesture state machine
   task automatic classify_tick(input logic down);
      logic [1:0] gesture_code;
      result_type r;
      gesture_code = GEST_NONE;
      case (key_phase)
         PH_DEB1: begin
            tick_count = bump8(tick_count);
            elapsed_ticks = bump16(elapsed_ticks);
            if (tick_count >= model_cfg.debounce_ticks)
               key_phase = down ? PH_PRESSED : PH_IDLE;
         end
         PH_PRESSED: begin
            elapsed_ticks = bump16(elapsed_ticks);
            if (!down) begin
               if (elapsed_ticks < model_cfg.long_ticks) begin
                  key_phase = PH_WAIT;
                  elapsed_ticks = '0;
               end else begin
                  gesture_code = GEST_LONG;
                  key_phase = PH_IDLE;
               end
            end
         end
         PH_WAIT: begin
            elapsed_ticks = bump16(elapsed_ticks);
            if (elapsed_ticks < model_cfg.double_ticks) begin
               if (down) begin
                  if (model_cfg.debounce_ticks == 0) begin
                     gesture_code = GEST_DOUBLE;
                     start_holdoff();
                  end else begin
                     tick_count = '0;
                     key_phase = PH_DEB2;
                  end
               end
            end else begin
               gesture_code = GEST_CLICK;
               key_phase = PH_IDLE;
            end
         end
         PH_DEB2: begin
            tick_count = bump8(tick_count);
            elapsed_ticks = bump16(elapsed_ticks);
            if (tick_count >= model_cfg.debounce_ticks) begin
               if (down) begin
                  gesture_code = GEST_DOUBLE;
                  start_holdoff();
               end else begin
                  key_phase = PH_WAIT;
               end
            end
         end
         PH_HOLDOFF: begin
            tick_count = bump8(tick_count);
            if (tick_count >= model_cfg.holdoff_ticks)
               key_phase = PH_IDLE;
         end
         default: begin
            key_phase = PH_IDLE;
            if (down) begin
               elapsed_ticks = '0;
               tick_count = '0;
               key_phase = (model_cfg.debounce_ticks == 0) ? PH_PRESSED : PH_DEB1;
            end
         end
      endcase
      if (gesture_code != GEST_NONE) begin
         case (gesture_code)
            GEST_CLICK: servo_setting = SET_CLICK;
            GEST_LONG:  servo_setting = SET_LONG;
            default:    servo_setting = SET_DOUBLE;
         endcase
         led_state = ~led_state;
      end
      r.gesture = gesture_code;
      r.servo_choice = servo_setting;
      if (servo_setting == SET_LONG)
         r.compare_value = model_cfg.duty_long;
      else if (servo_setting == SET_DOUBLE)
         r.compare_value = model_cfg.duty_double;
      else
         r.compare_value = model_cfg.duty_click;
      r.led_level = led_state;
      predicted_results.push_back(r);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
   endtask

   // 8-bit registers get junk in the upper byte, which must be dropped
   task automatic load_settings(input cfg_type c);
      write_reg(REG_DEBOUNCE, {8'($urandom), c.debounce_ticks});
      write_reg(REG_LONG, c.long_ticks);
      write_reg(REG_DOUBLE, c.double_ticks);
      write_reg(REG_HOLDOFF, {8'($urandom), c.holdoff_ticks});
      write_reg(REG_DUTY_CLICK, c.duty_click);
      write_reg(REG_DUTY_LONG, c.duty_long);
      write_reg(REG_DUTY_DOUBLE, c.duty_double);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      model_cfg = c;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (key_samples.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   // driver: key sample beats and rsp stall, changed on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (quiet) begin
            send_gap = 0;
            stall_gap = 0;
         end
         if (!req_valid || req_accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (key_samples.size() != 0) begin
               req_valid <= 1'b1;
               req_key_down <= key_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_gap = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: predict on accepted req beats, check accepted rsp beats
   always @(posedge clock) begin
      result_type want;
      cycle_count++;
      req_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_accepted = 1'b1;
            classify_tick(req_key_down);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               report_error("rsp beat with no prediction waiting");
            end else begin
               want = predicted_results.pop_front();
               if (rsp_gesture !== want.gesture)
                  report_error($sformatf("gesture got %0d want %0d",
                                         rsp_gesture, want.gesture));
               if (rsp_servo_choice !== want.servo_choice)
                  report_error($sformatf("servo_choice got %0d want %0d",
                                         rsp_servo_choice, want.servo_choice));
               if (rsp_compare_value !== want.compare_value)
                  report_error($sformatf("compare_value got %h want %h",
                                         rsp_compare_value, want.compare_value));
               if (rsp_led_level !== want.led_level)
                  report_error($sformatf("led_level got %b want %b",
                                         rsp_led_level, want.led_level));
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** key_gesture_servo_selector: FAILED **");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      int phase_ticks;
      int pick;
      int run_a;
      int run_b;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: bounce, then a double press into holdoff
      queue_level(1'b1, 10);
      queue_level(1'b0, 5);
      queue_level(1'b1, 40);
      queue_level(1'b0, 30);
      queue_level(1'b1, 30);
      queue_level(1'b0, 60);
      wait_drained();

      // short settings and zeros: bounce, click, long, double, bouncing second press,
      // window running out while the second press is confirmed
      foreach (directed_cfgs[i]) begin
         load_settings(directed_cfgs[i]);
         foreach (pattern_runs[j])
            queue_level(j % 2 == 0, pattern_runs[j]);
         wait_drained();
      end

      // largest settings: longest debounce, release into a wide window
      c = '{8'd255, 16'd65535, 16'd65535, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF};
      load_settings(c);
      queue_level(1'b1, 260);
      queue_level(1'b0, 3);
      wait_drained();

      // random gesture sequences under random short settings
      for (int p = 0; p < RANDOM_SETTINGS; p++) begin
         c.debounce_ticks = 8'($urandom_range(0, 4));
         c.long_ticks = 16'($urandom_range(0, 20));
         c.double_ticks = 16'($urandom_range(0, 12));
         c.holdoff_ticks = 8'($urandom_range(0, 5));
         c.duty_click = 16'($urandom);
         c.duty_long = 16'($urandom);
         c.duty_double = 16'($urandom);
         quiet = (p == RANDOM_SETTINGS - 1) || ($urandom_range(0, 4) == 0);
         load_settings(c);
         phase_ticks = 0;
         while (phase_ticks < RANDOM_TICKS / RANDOM_SETTINGS) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               run_a = $urandom_range(1, c.debounce_ticks + c.long_ticks + 3);
               if (pick < 4)
                  run_b = $urandom_range(1, c.double_ticks + 4);
               else
                  run_b = $urandom_range(1, c.double_ticks + 1);
               queue_level(1'b1, run_a);
               queue_level(1'b0, run_b);
               phase_ticks += run_a + run_b;
               if (pick >= 4) begin
                  run_a = $urandom_range(1, c.debounce_ticks + 3);
                  run_b = $urandom_range(1, c.holdoff_ticks + c.double_ticks + 4);
                  queue_level(1'b1, run_a);
                  queue_level(1'b0, run_b);
                  phase_ticks += run_a + run_b;
               end
            end else begin
               run_a = $urandom_range(1, 12);
               repeat (run_a) key_samples.push_back(1'($urandom_range(0, 1)));
               phase_ticks += run_a;
            end
         end
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (predicted_results.size() != 0)
         report_error($sformatf("%0d predicted beats never came", predicted_results.size()));
      if (error_count == 0)
         $display("** key_gesture_servo_selector: PASSED **");
      else
         $display("** key_gesture_servo_selector: FAILED **");
      $finish;
   end

endmodule

// File: key_gesture_servo_selector.f
+incdir+design
design/kgss_pkg.sv
design/kgss_csr.sv
design/kgss_step.sv
design/key_gesture_servo_selector.sv
sim/tb_key_gesture_servo_selector.sv
